FILE: src/qltu_pkg.sv
package qltu_pkg;

  // Table geometry
  localparam int NumStates  = 1024;
  localparam int StateW     = $clog2(NumStates);
  localparam int NumActions = 8;
  localparam int ActIdxW    = $clog2(NumActions);

  // Port field widths
  localparam int KindW   = 2;
  localparam int IdW     = 10;
  localparam int ActW    = 3;
  localparam int ValW    = 16;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 2;
  localparam int RowW    = ValW * NumActions;

  // Arithmetic widths: error term in Q8.24, product in Q8.40
  localparam int GmW   = 33;
  localparam int ErrW  = 34;
  localparam int ProdW = 51;
  localparam int DltW  = ProdW - 32;
  localparam int SumW  = DltW + 1;

  typedef logic signed [ValW-1:0] qval_t;
  typedef qval_t [NumActions-1:0] row_t;

  typedef enum logic [KindW-1:0] {
    KindLoad  = 2'd0,
    KindImm   = 2'd1,
    KindDelay = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegLearnRate   = 2'd0,
    RegDiscount    = 2'd1,
    RegInvalidNext = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StRdMax,
    StRdTgt,
    StErr,
    StMul,
    StWb,
    StPush
  } state_e;

  // Lowest index wins on ties
  function automatic logic [ActIdxW-1:0] row_argmax(row_t row);
    qval_t               best;
    logic [ActIdxW-1:0]  idx;
    best = row[0];
    idx  = '0;
    for (int i = 1; i < NumActions; i++) begin
      if (signed'(row[i]) > signed'(best)) begin
        best = row[i];
        idx  = ActIdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: src/q_learning_table_update_core.sv
// Tabular Q-learning update engine.
// Input channel: one word per item (kind, state ids, action, reward, load
// value, flags), accepted when in_valid_i is high and in_stall_o is low.
// Output channel: one result word per item (new_value_o, wrote_o,
// best_action_o), taken when out_valid_o is high and out_stall_i is low.
// Config: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 alpha,
// 1 gamma, 2 stand-in maxQ); write only while the engine is idle.
// Throughput: one item at a time. The Q table is a single-port RAM with
// a registered read; an update reads the s' row, then the target row,
// forms the error (gamma multiply), multiplies by alpha, then writes back.
// A load reads only the target row and skips the multiply; an immediate
// update with invalid s' skips the s' read; an item that writes nothing
// reads no row. The result word appears in the same cycle the engine is
// ready again.
// Reset clears the config registers to their defaults and the stored prior
// state; the table itself is undefined until loaded. A stalled result is
// held in the output register; the engine then waits in its final state
// until the result is taken.
module q_learning_table_update_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [qltu_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [qltu_pkg::CfgW-1:0]    cfg_data_i,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [qltu_pkg::KindW-1:0]   kind_i,
  input  logic [qltu_pkg::IdW-1:0]     state_id_i,
  input  logic                         state_ok_i,
  input  logic [qltu_pkg::ActW-1:0]    action_i,
  input  logic signed [qltu_pkg::ValW-1:0] reward_i,
  input  logic [qltu_pkg::IdW-1:0]     next_state_id_i,
  input  logic                         next_ok_i,
  input  logic                         constrained_i,
  input  logic signed [qltu_pkg::ValW-1:0] load_value_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [qltu_pkg::ValW-1:0] new_value_o,
  output logic                         wrote_o,
  output logic [qltu_pkg::ActW-1:0]    best_action_o
);

  import qltu_pkg::*;

  state_e state_q, state_d;

  // config registers
  logic [CfgW-1:0] learn_rate_q, discount_q;
  qval_t           invalid_next_q;

  // delayed-update memory of the previous state
  logic [StateW-1:0] prior_state_q;
  logic              prior_valid_q;

  // item registers
  kind_e              kind_q;
  logic [ActIdxW-1:0] act_q;
  qval_t              reward_q, load_q, maxq_q;
  logic [StateW-1:0]  tgt_q, maxrow_q;
  logic               has_max_q;

  // datapath registers
  row_t                    row_q;
  logic signed [ErrW-1:0]  err_q;
  logic signed [ProdW-1:0] prod_q;

  // result
  qval_t           res_val_q;
  logic            res_wrote_q;
  logic [ActW-1:0] res_best_q;
  logic            out_valid_q;
  qval_t           out_val_q;
  logic            out_wrote_q;
  logic [ActW-1:0] out_best_q;

  // RAM port
  logic              mem_re, mem_we;
  logic [StateW-1:0] mem_addr;
  row_t              mem_wdata, mem_rdata;

  // accept decode
  logic              in_acc, acc_act_ok, acc_wr, acc_has_max;
  logic [StateW-1:0] acc_tgt, acc_maxrow;
  kind_e             acc_kind;
  logic              out_free;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign acc_act_ok = 32'(action_i) < NumActions;
  assign acc_kind   = kind_e'(kind_i);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    acc_wr      = 1'b0;
    acc_has_max = 1'b0;
    acc_tgt     = StateW'(state_id_i);
    acc_maxrow  = StateW'(next_state_id_i);
    unique case (kind_i)
      KindLoad: begin
        acc_wr = acc_act_ok;
      end
      KindImm: begin
        acc_wr      = acc_act_ok && state_ok_i;
        acc_has_max = next_ok_i;
      end
      KindDelay: begin
        acc_wr      = !constrained_i && acc_act_ok && prior_valid_q && state_ok_i;
        acc_has_max = 1'b1;
        acc_tgt     = prior_state_q;
        acc_maxrow  = StateW'(state_id_i);
      end
      default: begin
        acc_wr = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Arithmetic
  // ---------------------------------------------------------------------
  qval_t                  q_cur, q_wb, new_val, row_max;
  logic signed [GmW-1:0]  gm;
  logic signed [ErrW-1:0] err_d;
  logic signed [ProdW-1:0] prod_d, rnd;
  logic signed [DltW-1:0] delta;
  logic signed [SumW-1:0] sum;
  row_t                   row_new;

  // maxQ of the s' row while it sits on the RAM output
  assign row_max = mem_rdata[row_argmax(mem_rdata)];

  // Q8.24 error: r*2^16 + gamma*maxQ - Q*2^16
  assign q_cur = mem_rdata[act_q];
  assign gm    = GmW'(signed'({1'b0, discount_q})) * GmW'(maxq_q);
  assign err_d = ErrW'(signed'({reward_q, 16'h0})) + ErrW'(gm)
               - ErrW'(signed'({q_cur, 16'h0}));

  // Q8.40 product, rounded half up to Q8.8
  assign prod_d = ProdW'(signed'({1'b0, learn_rate_q})) * ProdW'(err_q);
  assign rnd    = prod_q + ProdW'(64'sh8000_0000);
  assign delta  = rnd[ProdW-1:32];
  assign q_wb   = row_q[act_q];
  assign sum    = SumW'(q_wb) + SumW'(delta);

  always_comb begin
    if (kind_q == KindLoad) begin
      new_val = load_q;
    end else if (sum > SumW'(32767)) begin
      new_val = 16'sh7FFF;
    end else if (sum < -SumW'(32768)) begin
      new_val = 16'sh8000;
    end else begin
      new_val = sum[ValW-1:0];
    end
  end

  always_comb begin
    row_new        = row_q;
    row_new[act_q] = new_val;
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (!acc_wr) begin
            state_d = StPush;
          end else if (acc_has_max) begin
            state_d = StRdMax;
          end else begin
            state_d = StRdTgt;
          end
        end
      end
      StRdMax: state_d = StRdTgt;
      StRdTgt: state_d = StErr;
      StErr:   state_d = (kind_q == KindLoad) ? StWb : StMul;
      StMul:   state_d = StWb;
      StWb:    state_d = StPush;
      StPush: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = tgt_q;
    mem_wdata  = row_new;
    unique case (state_q)
      StIdle:  in_stall_o = 1'b0;
      StRdMax: begin
        mem_re   = 1'b1;
        mem_addr = maxrow_q;
      end
      StRdTgt: mem_re = 1'b1;
      StWb:    mem_we = 1'b1;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // config and prior state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_rate_q   <= 16'd6554;
      discount_q     <= 16'd58982;
      invalid_next_q <= -16'sd256;
      prior_state_q  <= '0;
      prior_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegLearnRate:   learn_rate_q   <= cfg_data_i;
          RegDiscount:    discount_q     <= cfg_data_i;
          RegInvalidNext: invalid_next_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc && acc_kind == KindDelay && !constrained_i) begin
        prior_state_q <= StateW'(state_id_i);
        prior_valid_q <= state_ok_i;
      end
    end
  end

  // item and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q    <= acc_kind;
      act_q     <= ActIdxW'(action_i);
      reward_q  <= reward_i;
      load_q    <= load_value_i;
      tgt_q     <= acc_tgt;
      maxrow_q  <= acc_maxrow;
      has_max_q <= acc_has_max;
      maxq_q    <= invalid_next_q;
    end
    if (state_q == StRdTgt && has_max_q) begin
      maxq_q <= row_max;
    end
    if (state_q == StErr) begin
      row_q <= mem_rdata;
      err_q <= err_d;
    end
    if (state_q == StMul) begin
      prod_q <= prod_d;
    end
    if (in_acc) begin
      res_val_q   <= '0;
      res_wrote_q <= 1'b0;
      res_best_q  <= '0;
    end else if (state_q == StWb) begin
      res_val_q   <= new_val;
      res_wrote_q <= 1'b1;
      res_best_q  <= ActW'(row_argmax(row_new));
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StPush && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StPush && out_free) begin
      out_val_q   <= res_val_q;
      out_wrote_q <= res_wrote_q;
      out_best_q  <= res_best_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign new_value_o   = out_val_q;
  assign wrote_o       = out_wrote_q;
  assign best_action_o = out_best_q;

  qltu_ram #(
    .Depth (NumStates),
    .Width (RowW)
  ) u_table (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("second word accepted while an item is in flight");

  a_wb_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWb |=> state_q == StPush && res_wrote_q)
    else $error("write-back not followed by a written result");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !wrote_o |-> new_value_o == '0 && best_action_o == '0)
    else $error("result without a write carries data");

  a_prior_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(prior_valid_q) |-> $past(in_acc && acc_kind == KindDelay))
    else $error("prior state changed outside a delayed update");

endmodule

FILE: src/qltu_ram.sv
module qltu_ram #(
  parameter int Depth = 1024,
  parameter int Width = 128
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/q_learning_table_update_checker.sv
module q_learning_table_update_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qltu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [qltu_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [qltu_pkg::KindW-1:0]    kind_i,
  input  logic [qltu_pkg::IdW-1:0]      state_id_i,
  input  logic                          state_ok_i,
  input  logic [qltu_pkg::ActW-1:0]     action_i,
  input  qltu_pkg::qval_t               reward_i,
  input  logic [qltu_pkg::IdW-1:0]      next_state_id_i,
  input  logic                          next_ok_i,
  input  logic                          constrained_i,
  input  qltu_pkg::qval_t               load_value_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  qltu_pkg::qval_t               new_value_i,
  input  logic                          wrote_i,
  input  logic [qltu_pkg::ActW-1:0]     best_action_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import qltu_pkg::*;

  localparam int    AlphaReset   = 6554;
  localparam int    GammaReset   = 58982;
  localparam qval_t StandInReset = -16'sd256;

  typedef struct {
    qval_t             value;
    logic              wrote;
    logic [ActW-1:0]   best;
    bit                best_known;
  } result_t;

  qval_t                 q_mem [NumStates][NumActions];
  logic [NumActions-1:0] seen [NumStates];
  int                    alpha;
  int                    gamma;
  qval_t                 stand_in;
  int                    last_row;
  bit                    last_ok;
  result_t               pending_results [$];
  int                    mismatches = 0;
  int                    depth = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = depth;

  // lowest index wins on ties
  function automatic int greedy_action(int row);
    int idx = 0;
    for (int i = 1; i < NumActions; i++) begin
      if (q_mem[row][i] > q_mem[row][idx]) idx = i;
    end
    return idx;
  endfunction

  // error in Q8.24, times alpha, round half up back to Q8.8, saturate
  function automatic qval_t td_update(int row, int act, qval_t r, qval_t maxq);
    longint q;
    longint err;
    longint prod;
    longint dlt;
    longint sum;
    q    = q_mem[row][act];
    err  = longint'(r) * 65536 + longint'(gamma) * longint'(maxq) - q * 65536;
    prod = longint'(alpha) * err;
    dlt  = (prod + (longint'(1) <<< 31)) >>> 32;
    sum  = q + dlt;
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    q_mem[row][act] = qval_t'(sum);
    seen[row][act]  = 1'b1;
    return qval_t'(sum);
  endfunction

  function automatic result_t apply_item(logic [KindW-1:0] kind, int sid, bit sok, int act,
                                         qval_t r, int nsid, bit nok, bit cons, qval_t ld);
    result_t res;
    int      row;
    qval_t   maxq;
    res = '{value: 16'sd0, wrote: 1'b0, best: '0, best_known: 1'b1};
    row = 0;
    case (kind)
      KindLoad: begin
        q_mem[sid][act] = ld;
        seen[sid][act]  = 1'b1;
        res.value = ld;
        res.wrote = 1'b1;
        row = sid;
      end
      KindImm: begin
        if (sok) begin
          maxq = nok ? q_mem[nsid][greedy_action(nsid)] : stand_in;
          res.value = td_update(sid, act, r, maxq);
          res.wrote = 1'b1;
          row = sid;
        end
      end
      KindDelay: begin
        if (!cons) begin
          if (last_ok && sok) begin
            maxq = q_mem[sid][greedy_action(sid)];
            row = last_row;
            res.value = td_update(row, act, r, maxq);
            res.wrote = 1'b1;
          end
          last_row = sid;
          last_ok  = sok;
        end
      end
      default: ;
    endcase
    if (res.wrote) begin
      res.best = ActW'(greedy_action(row));
      // argmax over a partly loaded row is undefined
      res.best_known = &seen[row];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] got,
                                 logic signed [31:0] want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      alpha    = AlphaReset;
      gamma    = GammaReset;
      stand_in = StandInReset;
      last_row = 0;
      last_ok  = 1'b0;
      pending_results.delete();
      foreach (seen[i]) seen[i] = '0;
      depth <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegLearnRate:   alpha    = int'(cfg_data_i);
          RegDiscount:    gamma    = int'(cfg_data_i);
          RegInvalidNext: stand_in = qval_t'(cfg_data_i);
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result word with none expected", new_value_i, 0);
        end else begin
          want = pending_results.pop_front();
          if (new_value_i !== want.value) report_mismatch("new_value", new_value_i, want.value);
          if (wrote_i !== want.wrote) report_mismatch("wrote", wrote_i, want.wrote);
          if (want.best_known && best_action_i !== want.best) begin
            report_mismatch("best_action", best_action_i, want.best);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pending_results.push_back(apply_item(kind_i, int'(state_id_i), state_ok_i,
                                             int'(action_i), reward_i, int'(next_state_id_i),
                                             next_ok_i, constrained_i, load_value_i));
      end
      depth <= pending_results.size();
    end
  end

endmodule

FILE: tb/q_learning_table_update_core_test.sv
module q_learning_table_update_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qltu_pkg::*;

  // kind code the engine must ignore
  localparam logic [KindW-1:0] KindSpare = 2'd3;

  localparam qval_t QMin = 16'sh8000;
  localparam qval_t QMax = 16'sh7fff;

  localparam int NumPhases     = 6;
  localparam int ItemsPerPhase = 270;
  localparam int PoolMax       = 40;   // rows fully loaded and safe to read
  localparam int DrainCycles   = 12;
  localparam int LongHold      = 200;

  typedef struct {
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   sid;
    logic             sok;
    logic [ActW-1:0]  act;
    qval_t            reward;
    logic [IdW-1:0]   nsid;
    logic             nok;
    logic             cons;
    qval_t            load;
  } word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [KindW-1:0]   kind_i;
  logic [IdW-1:0]     state_id_i;
  logic               state_ok_i;
  logic [ActW-1:0]    action_i;
  qval_t              reward_i;
  logic [IdW-1:0]     next_state_id_i;
  logic               next_ok_i;
  logic               constrained_i;
  qval_t              load_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  qval_t              new_value_o;
  logic               wrote_o;
  logic [ActW-1:0]    best_action_o;

  int mismatch_total;
  int results_owed;

  // stimulus bookkeeping
  int burst_left;
  int counted = 0;          // words sent, ignored kind excluded
  bit pooled [NumStates];
  int pool_rows [$];

  q_learning_table_update_core dut (.*);

  q_learning_table_update_checker result_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .kind_i          (kind_i),
    .state_id_i      (state_id_i),
    .state_ok_i      (state_ok_i),
    .action_i        (action_i),
    .reward_i        (reward_i),
    .next_state_id_i (next_state_id_i),
    .next_ok_i       (next_ok_i),
    .constrained_i   (constrained_i),
    .load_value_i    (load_value_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .new_value_i     (new_value_o),
    .wrote_i         (wrote_o),
    .best_action_i   (best_action_o),
    .fail_count_o    (mismatch_total),
    .pending_o       (results_owed)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic word_t make_word(logic [KindW-1:0] k, int sid, bit sok, int act,
                                      qval_t r, int nsid, bit nok, bit cons, qval_t ld);
    word_t w;
    w.kind   = k;
    w.sid    = IdW'(sid);
    w.sok    = sok;
    w.act    = ActW'(act);
    w.reward = r;
    w.nsid   = IdW'(nsid);
    w.nok    = nok;
    w.cons   = cons;
    w.load   = ld;
    return w;
  endfunction

  // Q8.8 value, biased toward the range ends and zero
  function automatic qval_t rand_val();
    case ($urandom_range(0, 9))
      0:       return QMin;
      1:       return QMax;
      2:       return 16'sd0;
      default: return qval_t'($urandom);
    endcase
  endfunction

  function automatic int pick_row();
    return pool_rows[$urandom_range(0, pool_rows.size() - 1)];
  endfunction

  function automatic int any_row();
    return $urandom_range(0, NumStates - 1);
  endfunction

  // Offer one word; valid stays up across a burst and drops in the gap
  // between bursts, so valid never toggles twice in one step.
  task automatic send_word(input word_t w);
    kind_i          <= w.kind;
    state_id_i      <= w.sid;
    state_ok_i      <= w.sok;
    action_i        <= w.act;
    reward_i        <= w.reward;
    next_state_id_i <= w.nsid;
    next_ok_i       <= w.nok;
    constrained_i   <= w.cons;
    load_value_i    <= w.load;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (w.kind != KindSpare) counted++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
    end
  endtask

  // Sender pauses until every result word has come back, then lets the
  // engine settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Only called while the engine is idle.
  task automatic write_reg(input reg_e idx, input logic [CfgW-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: stretches of free flow, light and heavy random stalls, and
  // now and then a long hold so the engine backs up into its input.
  initial begin
    int seg;
    int mode;
    int len;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    seg = 0;
    forever begin
      seg++;
      if (seg % 60 == 5) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(5, 40);
        repeat (len) begin
          case (mode)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= 1'($urandom_range(0, 1));
            default: out_stall_i <= ($urandom_range(0, 4) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    int    ph;
    int    target;
    int    pick;
    int    row;
    int    n;
    int    j;
    int    k;
    int    tmp;
    int    perm [NumActions];
    bit    sok;
    bit    nok;
    bit    cons;
    qval_t tie_val;
    qval_t seed_vals [2*NumActions];

    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    kind_i          = '0;
    state_id_i      = '0;
    state_ok_i      = 1'b0;
    action_i        = '0;
    reward_i        = '0;
    next_state_id_i = '0;
    next_ok_i       = 1'b0;
    constrained_i   = 1'b0;
    load_value_i    = '0;
    burst_left      = $urandom_range(1, 10);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- Directed part, reset register values ----
    // Row 0: range ends, a tie for the max (lowest index must win).
    // Row 1023: mostly mid-range values, tie at 5000.
    seed_vals = '{QMin, QMax, 16'sd0, 16'sd256, -16'sd256, QMax, 16'sd1, -16'sd1,
                  16'sd100, -16'sd100, 16'sd5000, -16'sd5000, 16'sd5000, 16'sd0,
                  QMin, 16'sd4999};
    for (j = 0; j < 2*NumActions; j++) begin
      // state_ok flips; loads must not care
      send_word(make_word(KindLoad, (j < NumActions) ? 0 : NumStates - 1, j % 2,
                          j % NumActions, 16'sd0, 0, 1'b0, 1'b0, seed_vals[j]));
    end
    pooled[0] = 1'b1;
    pooled[NumStates-1] = 1'b1;
    pool_rows.push_back(0);
    pool_rows.push_back(NumStates - 1);

    // immediate update with valid s', max reward on the min entry
    send_word(make_word(KindImm, 0, 1'b1, 0, QMax, NumStates - 1, 1'b1, 1'b0, 16'sd0));
    // invalid s': stand-in value replaces maxQ
    send_word(make_word(KindImm, NumStates - 1, 1'b1, 2, QMin, 77, 1'b0, 1'b0, 16'sd0));
    // invalid s: no write
    send_word(make_word(KindImm, 0, 1'b0, 3, 16'sd1000, NumStates - 1, 1'b1, 1'b0, 16'sd0));
    // delayed update with no prior state yet: records s
    send_word(make_word(KindDelay, 0, 1'b1, 4, 16'sd500, 0, 1'b0, 1'b0, 16'sd0));
    // constrained: skipped, prior untouched
    send_word(make_word(KindDelay, NumStates - 1, 1'b1, 5, 16'sd500, 0, 1'b0, 1'b1, 16'sd0));
    // prior row 0 updated using max of row 1023
    send_word(make_word(KindDelay, NumStates - 1, 1'b1, 7, 16'sd12345, 0, 1'b0, 1'b0,
                        16'sd0));
    // invalid s': no write, prior becomes invalid
    send_word(make_word(KindDelay, 555, 1'b0, 6, 16'sd1, 0, 1'b0, 1'b0, 16'sd0));
    // unused kind: ignored
    send_word(make_word(KindSpare, NumStates - 1, 1'b1, 7, QMax, NumStates - 1, 1'b1,
                        1'b1, QMax));
    // load ignores state_ok
    send_word(make_word(KindLoad, 0, 1'b0, 3, 16'sd0, 0, 1'b0, 1'b0, QMin));
    drain();

    // ---- Random part, one register setting per phase ----
    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        1: begin
          write_reg(RegLearnRate, 16'hffff);
          write_reg(RegDiscount, 16'hffff);
          write_reg(RegInvalidNext, 16'h7fff);
        end
        2: begin
          write_reg(RegLearnRate, 16'h0000);
          write_reg(RegDiscount, 16'h0000);
          write_reg(RegInvalidNext, 16'h8000);
        end
        4: begin
          write_reg(RegLearnRate, 16'h8000);
          write_reg(RegDiscount, 16'h0000);
          write_reg(RegInvalidNext, 16'h0000);
        end
        3, 5: begin
          write_reg(RegDiscount, CfgW'($urandom));
          write_reg(RegLearnRate, CfgW'($urandom));
          write_reg(RegInvalidNext, CfgW'($urandom));
        end
        default: ;  // first phase keeps the reset values
      endcase

      target = counted + ItemsPerPhase;
      while (counted < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 8 && pool_rows.size() < PoolMax) begin
          // bring a fresh row into the pool: all actions, shuffled order
          do row = any_row(); while (pooled[row]);
          for (j = 0; j < NumActions; j++) perm[j] = j;
          for (j = NumActions - 1; j > 0; j--) begin
            k = $urandom_range(0, j);
            tmp = perm[j];
            perm[j] = perm[k];
            perm[k] = tmp;
          end
          tie_val = rand_val();
          for (j = 0; j < NumActions; j++) begin
            send_word(make_word(KindLoad, row, 1'($urandom), perm[j], rand_val(),
                                any_row(), 1'($urandom), 1'($urandom),
                                ($urandom_range(0, 3) == 0) ? tie_val : rand_val()));
          end
          pooled[row] = 1'b1;
          pool_rows.push_back(row);
        end else if (pick < 38) begin
          // episode of delayed updates; a valid s' always comes from the pool
          n = $urandom_range(3, 12);
          repeat (n) begin
            cons = ($urandom_range(0, 9) == 0);
            sok  = ($urandom_range(0, 9) != 0);
            row  = (sok && !cons) ? pick_row() : any_row();
            send_word(make_word(KindDelay, row, sok, $urandom_range(0, NumActions - 1),
                                rand_val(), any_row(), 1'($urandom), cons, rand_val()));
          end
        end else if (pick < 72) begin
          // run of immediate updates
          n = $urandom_range(2, 10);
          repeat (n) begin
            sok = ($urandom_range(0, 19) != 0);
            nok = ($urandom_range(0, 4) != 0);
            send_word(make_word(KindImm, sok ? pick_row() : any_row(), sok,
                                $urandom_range(0, NumActions - 1), rand_val(),
                                (sok && nok) ? pick_row() : any_row(), nok,
                                1'($urandom), rand_val()));
          end
        end else if (pick < 86) begin
          // overwrite one entry of a loaded row
          send_word(make_word(KindLoad, pick_row(), 1'($urandom),
                              $urandom_range(0, NumActions - 1), rand_val(), any_row(),
                              1'($urandom), 1'($urandom), rand_val()));
        end else begin
          // noise: mostly words that read nothing from the table, plus loads to random rows
          case ($urandom_range(0, 3))
            0: send_word(make_word(KindSpare, any_row(), 1'($urandom), $urandom,
                                   rand_val(), any_row(), 1'($urandom), 1'($urandom),
                                   rand_val()));
            1: send_word(make_word(KindImm, any_row(), 1'b0, $urandom, rand_val(),
                                   any_row(), 1'($urandom), 1'($urandom), rand_val()));
            2: send_word(make_word(KindDelay, any_row(), 1'($urandom), $urandom,
                                   rand_val(), any_row(), 1'($urandom), 1'b1,
                                   rand_val()));
            default: send_word(make_word(KindLoad, any_row(), 1'($urandom), $urandom,
                                         rand_val(), any_row(), 1'($urandom),
                                         1'($urandom), rand_val()));
          endcase
        end
      end
      drain();
    end

    if (mismatch_total == 0 && results_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/qltu_pkg.sv
src/qltu_ram.sv
src/q_learning_table_update_core.sv
tb/q_learning_table_update_checker.sv
tb/q_learning_table_update_core_test.sv
